// ----- sv/bgf_pkg.sv -----
// ---------------------------------------------------------------------------
// bgf_pkg
// Shared types and constants for the Burgers Godunov flux stencil core.
// ---------------------------------------------------------------------------
package bgf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 12;
	localparam int RATE_W   = 32;
	localparam int INV_W    = 24;
	localparam int SQ_W     = 31;               // u*u of a 16-bit signed value
	localparam int DIFF_W   = 32;               // difference of two half-squares
	localparam int PROD_W   = DIFF_W + INV_W + 1;
	localparam int RATE_SHIFT = 21;

	localparam logic [INV_W-1:0] INV_RESET = 24'd256;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (RATE_SHIFT - 1);
	localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7fff_ffff;
	localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh8000_0000;

	// APB register map
	localparam int PADDR_W = 3;
	localparam logic REG_INV_CELL_WIDTH = 1'b0;  // paddr[2] selects the register

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT1,
		ST_WAIT2,
		ST_EMIT
	} state_t;

	// which three-cell window feeds the flux pipeline
	typedef enum logic [1:0] {
		JOB_INTERIOR,   // older, newer, current
		JOB_LAST,       // newer, current, first
		JOB_WRAP        // current, first, second
	} job_t;

	typedef struct packed {
		logic               capture;
		logic               store_first;
		logic               store_second;
		logic               shift;
		logic               clear;
		logic               load_out;
		job_t               job;
		logic [INDEX_W-1:0] index;
		logic               short_field;
		logic               fin;
	} cmd_t;

endpackage

// ----- sv/bgf_if.sv -----
// ---------------------------------------------------------------------------
// bgf_in_if / bgf_out_if
// Valid/ready channels for input samples and result items.
// ---------------------------------------------------------------------------
interface bgf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bgf_pkg::SAMPLE_W-1:0] sample;
	logic                                 last_cell;

	modport source (output valid, output sample, output last_cell, input ready);
	modport sink   (input valid, input sample, input last_cell, output ready);
endinterface

interface bgf_out_if;
	logic                                valid;
	logic                                ready;
	logic [bgf_pkg::INDEX_W-1:0]         cell_index;
	logic signed [bgf_pkg::RATE_W-1:0]   rate;
	logic [bgf_pkg::SAMPLE_W-1:0]        max_speed;
	logic                                status;
	logic                                final_result;

	modport source (output valid, output cell_index, output rate, output max_speed,
		output status, output final_result, input ready);
	modport sink   (input valid, input cell_index, input rate, input max_speed,
		input status, input final_result, output ready);
endinterface

// ----- sv/burgers_godunov_flux_stencil_core.sv -----
// An item that yields no result (first two samples) is taken straight from ST_IDLE.
// An item that yields a result passes through issue, three flux pipeline stages
// (squares, flux difference, 1/dx multiply), then round/saturate into the result register.
// The last item of a field yields its three results in turn; a short field yields one.
// Stalls on the result side hold the core only while the result register is still full.
// Reset (arst_n low) clears the field state and sets inv_cell_width to 1.0 (256).
// ---------------------------------------------------------------------------
// burgers_godunov_flux_stencil_core
// Godunov flux stencil for a periodic 1-D Burgers field with APB config port.
// ---------------------------------------------------------------------------
module burgers_godunov_flux_stencil_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bgf_in_if.sink                        samples,
	bgf_out_if.source                     results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgf_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [bgf_pkg::INV_W-1:0] inv_q;
	bgf_pkg::cmd_t             cmd;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inv_q <= bgf_pkg::INV_RESET;
		else if (psel && penable && pwrite && pready && paddr[2] == bgf_pkg::REG_INV_CELL_WIDTH)
			inv_q <= pwdata[bgf_pkg::INV_W-1:0];
	end

	assign prdata = (paddr[2] == bgf_pkg::REG_INV_CELL_WIDTH) ? {8'd0, inv_q} : 32'd0;

	bgf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last_cell),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	bgf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_sample      (samples.sample),
		.inv_cell_width (inv_q),
		.cell_index     (results.cell_index),
		.rate           (results.rate),
		.max_speed      (results.max_speed),
		.status         (results.status),
		.final_result   (results.final_result)
	);

	// a short-field error is always the final result
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status) |-> results.final_result)
		else $error("error status on non-final result");

	// the final result always belongs to cell 0
	a_final_index: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.final_result) |-> (results.cell_index == '0))
		else $error("final result not tagged with cell 0");

	// speed is reported only on the final result
	a_speed_final: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.final_result) |-> (results.max_speed == '0))
		else $error("max_speed on non-final result");

endmodule

// ----- sv/bgf_ctrl.sv -----
// ---------------------------------------------------------------------------
// bgf_ctrl
// Sequencer: tracks the field count, issues flux windows, owns output valid.
// ---------------------------------------------------------------------------
module bgf_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_last,
	output logic                            in_ready,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bgf_pkg::cmd_t                   cmd
);

	bgf_pkg::state_t                 state_q, state_d;
	bgf_pkg::job_t                   job_q, job_d;
	logic                            last_q, last_d;
	logic                            short_q, short_d;
	logic                            have_two_q, have_two_d;
	logic                            out_valid_q, out_valid_d;
	logic [bgf_pkg::INDEX_W-1:0]     cells_q, cells_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bgf_pkg::ST_IDLE;
			job_q       <= bgf_pkg::JOB_INTERIOR;
			last_q      <= 1'b0;
			short_q     <= 1'b0;
			have_two_q  <= 1'b0;
			out_valid_q <= 1'b0;
			cells_q     <= '0;
		end else begin
			state_q     <= state_d;
			job_q       <= job_d;
			last_q      <= last_d;
			short_q     <= short_d;
			have_two_q  <= have_two_d;
			out_valid_q <= out_valid_d;
			cells_q     <= cells_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		job_d      = job_q;
		last_d     = last_q;
		short_d    = short_q;
		have_two_d = have_two_q;
		cells_d    = cells_q;
		in_ready   = 1'b0;

		cmd              = '0;
		cmd.job          = job_q;
		cmd.short_field  = short_q;
		cmd.fin          = short_q || (job_q == bgf_pkg::JOB_WRAP);
		case (job_q)
			bgf_pkg::JOB_INTERIOR: cmd.index = cells_q - 1'b1;
			bgf_pkg::JOB_LAST:     cmd.index = cells_q;
			default:               cmd.index = '0;
		endcase
		if (short_q)
			cmd.index = '0;

		case (state_q)
			bgf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (!have_two_q) begin
						cmd.store_first  = (cells_q == '0);
						cmd.store_second = (cells_q != '0);
						if (in_last) begin
							short_d = 1'b1;
							state_d = bgf_pkg::ST_EMIT;
						end else begin
							have_two_d = (cells_q != '0);
							cells_d    = cells_q + 1'b1;
						end
					end else begin
						job_d   = bgf_pkg::JOB_INTERIOR;
						last_d  = in_last;
						state_d = bgf_pkg::ST_ISSUE;
					end
				end
			end
			bgf_pkg::ST_ISSUE: state_d = bgf_pkg::ST_WAIT1;
			bgf_pkg::ST_WAIT1: state_d = bgf_pkg::ST_WAIT2;
			bgf_pkg::ST_WAIT2: state_d = bgf_pkg::ST_EMIT;
			bgf_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					if (short_q) begin
						cmd.clear  = 1'b1;
						short_d    = 1'b0;
						cells_d    = '0;
						have_two_d = 1'b0;
						state_d    = bgf_pkg::ST_IDLE;
					end else begin
						case (job_q)
							bgf_pkg::JOB_INTERIOR: begin
								if (last_q) begin
									job_d   = bgf_pkg::JOB_LAST;
									state_d = bgf_pkg::ST_ISSUE;
								end else begin
									cmd.shift = 1'b1;
									cells_d   = cells_q + 1'b1;
									state_d   = bgf_pkg::ST_IDLE;
								end
							end
							bgf_pkg::JOB_LAST: begin
								job_d   = bgf_pkg::JOB_WRAP;
								state_d = bgf_pkg::ST_ISSUE;
							end
							default: begin
								cmd.clear  = 1'b1;
								cells_d    = '0;
								have_two_d = 1'b0;
								state_d    = bgf_pkg::ST_IDLE;
							end
						endcase
					end
				end
			end
			default: state_d = bgf_pkg::ST_IDLE;
		endcase

		if (cmd.load_out)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

	// a result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// the final result of a field returns the field state to empty
	a_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && cmd.fin) |=> (!have_two_q && cells_q == '0))
		else $error("field state not cleared after final result");

	// a window is only issued once two samples are stored
	a_issue_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgf_pkg::ST_ISSUE) |-> have_two_q)
		else $error("flux window issued before two samples stored");

endmodule

// ----- sv/bgf_datapath.sv -----
// ---------------------------------------------------------------------------
// bgf_datapath
// Sample store, three-stage Godunov flux pipeline and result register.
// ---------------------------------------------------------------------------
module bgf_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bgf_pkg::cmd_t                         cmd,
	input  logic signed [bgf_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic [bgf_pkg::INV_W-1:0]             inv_cell_width,
	output logic [bgf_pkg::INDEX_W-1:0]           cell_index,
	output logic signed [bgf_pkg::RATE_W-1:0]     rate,
	output logic [bgf_pkg::SAMPLE_W-1:0]          max_speed,
	output logic                                  status,
	output logic                                  final_result
);

	logic signed [bgf_pkg::SAMPLE_W-1:0] first_q, second_q, older_q, newer_q, cur_q;
	logic [bgf_pkg::SAMPLE_W-1:0]        peak_q, mag;

	logic signed [bgf_pkg::SAMPLE_W-1:0] op_l, op_c, op_r;
	logic [bgf_pkg::SQ_W-1:0]            sq_l_s1, sq_c_s1, sq_r_s1;
	logic                                le_lc_s1, same_lc_s1, le_cr_s1, same_cr_s1;
	logic [bgf_pkg::SQ_W-1:0]            flux_l, flux_r;
	logic signed [bgf_pkg::DIFF_W-1:0]   diff_s2;
	logic signed [bgf_pkg::PROD_W-1:0]   prod_s3, rounded;
	logic signed [bgf_pkg::RATE_W-1:0]   sat_rate;
	logic signed [bgf_pkg::INV_W:0]      inv_ext;
	logic signed [2*bgf_pkg::SAMPLE_W-1:0] pl, pc, pr;

	assign mag = in_sample[bgf_pkg::SAMPLE_W-1] ? bgf_pkg::SAMPLE_W'(-in_sample) : in_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			peak_q   <= '0;
		end else if (cmd.clear) begin
			first_q  <= '0;
			second_q <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			peak_q   <= '0;
		end else begin
			if (cmd.capture && mag > peak_q)
				peak_q <= mag;
			if (cmd.store_first) begin
				first_q <= in_sample;
				newer_q <= in_sample;
			end else if (cmd.store_second) begin
				second_q <= in_sample;
				older_q  <= newer_q;
				newer_q  <= in_sample;
			end else if (cmd.shift) begin
				older_q <= newer_q;
				newer_q <= cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			cur_q <= in_sample;
	end

	// window select
	always_comb begin
		case (cmd.job)
			bgf_pkg::JOB_INTERIOR: begin
				op_l = older_q; op_c = newer_q; op_r = cur_q;
			end
			bgf_pkg::JOB_LAST: begin
				op_l = newer_q; op_c = cur_q; op_r = first_q;
			end
			default: begin
				op_l = cur_q; op_c = first_q; op_r = second_q;
			end
		endcase
	end

	assign pl = op_l * op_l;
	assign pc = op_c * op_c;
	assign pr = op_r * op_r;

	// stage 1: squares and face orderings
	always_ff @(posedge clk) begin
		sq_l_s1    <= pl[bgf_pkg::SQ_W-1:0];
		sq_c_s1    <= pc[bgf_pkg::SQ_W-1:0];
		sq_r_s1    <= pr[bgf_pkg::SQ_W-1:0];
		le_lc_s1   <= (op_l <= op_c);
		le_cr_s1   <= (op_c <= op_r);
		same_lc_s1 <= (op_l > 0 && op_c > 0) || (op_l < 0 && op_c < 0);
		same_cr_s1 <= (op_c > 0 && op_r > 0) || (op_c < 0 && op_r < 0);
	end

	// Godunov face flux: rarefaction takes min or zero across sonic point,
	// shock takes max
	always_comb begin
		if (le_lc_s1)
			flux_l = same_lc_s1 ? ((sq_l_s1 < sq_c_s1) ? sq_l_s1 : sq_c_s1) : '0;
		else
			flux_l = (sq_l_s1 > sq_c_s1) ? sq_l_s1 : sq_c_s1;
		if (le_cr_s1)
			flux_r = same_cr_s1 ? ((sq_c_s1 < sq_r_s1) ? sq_c_s1 : sq_r_s1) : '0;
		else
			flux_r = (sq_c_s1 > sq_r_s1) ? sq_c_s1 : sq_r_s1;
	end

	// stage 2: flux difference
	always_ff @(posedge clk) begin
		diff_s2 <= $signed({1'b0, flux_l}) - $signed({1'b0, flux_r});
	end

	assign inv_ext = $signed({1'b0, inv_cell_width});

	// stage 3: scale by 1/dx
	always_ff @(posedge clk) begin
		prod_s3 <= bgf_pkg::PROD_W'(diff_s2) * bgf_pkg::PROD_W'(inv_ext);
	end

	// round half up, floor shift by 21, saturate to 32 bits
	assign rounded = prod_s3 + bgf_pkg::ROUND_HALF;
	always_comb begin
		if (!rounded[bgf_pkg::PROD_W-1] && (|rounded[bgf_pkg::PROD_W-2:bgf_pkg::RATE_SHIFT+bgf_pkg::RATE_W-1]))
			sat_rate = bgf_pkg::RATE_MAX;
		else if (rounded[bgf_pkg::PROD_W-1] && !(&rounded[bgf_pkg::PROD_W-2:bgf_pkg::RATE_SHIFT+bgf_pkg::RATE_W-1]))
			sat_rate = bgf_pkg::RATE_MIN;
		else
			sat_rate = rounded[bgf_pkg::RATE_SHIFT+bgf_pkg::RATE_W-1:bgf_pkg::RATE_SHIFT];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_index   <= cmd.index;
			rate         <= cmd.short_field ? '0 : sat_rate;
			max_speed    <= cmd.fin ? peak_q : '0;
			status       <= cmd.short_field;
			final_result <= cmd.fin;
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Testbench for burgers_godunov_flux_stencil_core. Streams periodic fields of
// cell averages with random gaps and stalls on both channels. Each accepted
// sample goes to a Godunov flux predictor that queues the expected rate items.
// Every result item is checked field by field against the oldest entry.
// The 1/dx register is written over APB between fields and read back.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bgf_pkg::*;

	localparam logic [PADDR_W-1:0] INV_WIDTH_ADDR = 3'd0;  // register 0
	localparam logic [PADDR_W-1:0] SPARE_ADDR     = 3'd4;  // no register here
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 30;
	localparam int RANDOM_ITEMS  = 250;
	localparam int MAX_PRINTS    = 60;

	typedef struct packed {
		logic [INDEX_W-1:0]         cell_index;
		logic signed [RATE_W-1:0]   rate;
		logic [SAMPLE_W-1:0]        max_speed;
		logic                       status;
		logic                       final_result;
	} rate_item_t;

	class godunov_rate_board;
		logic [INV_W-1:0]           inv_width;
		logic signed [SAMPLE_W-1:0] first_u, second_u, older_u, newer_u;
		logic [INDEX_W-1:0]         cells_seen;
		logic [16:0]                peak;
		bit                         have_two;
		rate_item_t                 pending_rates[$];
		int                         mismatches, checked, fields, short_fields;

		function new();
			inv_width = INV_RESET;
			clear_field();
		endfunction

		function void clear_field();
			first_u = '0;
			second_u = '0;
			older_u = '0;
			newer_u = '0;
			cells_seen = '0;
			peak = '0;
			have_two = 1'b0;
		endfunction

		// face flux as u*u, i.e. the half-square with 25 fraction bits
		function longint godunov_face(int a, int b);
			longint sa, sb;
			sa = longint'(a) * a;
			sb = longint'(b) * b;
			if (a <= b) begin
				if ((a > 0 && b > 0) || (a < 0 && b < 0))
					return (sa < sb) ? sa : sb;
				return 0;
			end
			return (sa > sb) ? sa : sb;
		endfunction

		function logic signed [RATE_W-1:0] cell_rate(int l, int c, int r);
			longint d, p, q;
			d = godunov_face(l, c) - godunov_face(c, r);
			p = d * longint'(inv_width) + (longint'(1) << (RATE_SHIFT - 1));
			q = p >>> RATE_SHIFT;    // floor, same as round half up here
			if (q > longint'(RATE_MAX)) q = longint'(RATE_MAX);
			if (q < longint'(RATE_MIN)) q = longint'(RATE_MIN);
			return RATE_W'(q);
		endfunction

		function void queue_rate(logic [INDEX_W-1:0] idx, logic signed [RATE_W-1:0] rate,
			logic [SAMPLE_W-1:0] speed, logic status, logic fin);
			rate_item_t item;
			item.cell_index = idx;
			item.rate = rate;
			item.max_speed = speed;
			item.status = status;
			item.final_result = fin;
			pending_rates.push_back(item);
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] u, logic last);
			int mag;
			mag = (u < 0) ? -int'(u) : int'(u);
			if (mag > int'(peak))
				peak = 17'(mag);
			if (!have_two) begin
				if (cells_seen == 0) begin
					first_u = u;
					newer_u = u;
				end else begin
					second_u = u;
					older_u = newer_u;
					newer_u = u;
					have_two = 1'b1;
				end
				if (last) begin
					queue_rate('0, '0, peak[SAMPLE_W-1:0], 1'b1, 1'b1);
					fields++;
					short_fields++;
					clear_field();
				end else
					cells_seen++;
				return;
			end
			queue_rate(cells_seen - 1'b1, cell_rate(older_u, newer_u, u), '0, 1'b0, 1'b0);
			if (!last) begin
				older_u = newer_u;
				newer_u = u;
				cells_seen++;
				return;
			end
			// end of field: last cell, then cell 0 from the kept pair
			queue_rate(cells_seen, cell_rate(newer_u, u, first_u), '0, 1'b0, 1'b0);
			queue_rate('0, cell_rate(u, first_u, second_u), peak[SAMPLE_W-1:0], 1'b0, 1'b1);
			fields++;
			clear_field();
		endfunction

		function int pending();
			return pending_rates.size();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("%0t ERROR %s", $realtime, msg);
		endtask

		task compare_rate(rate_item_t got);
			rate_item_t want;
			checked++;
			if (pending_rates.size() == 0) begin
				report_mismatch($sformatf("unexpected item: cell %0d rate %0d",
					got.cell_index, got.rate));
				return;
			end
			want = pending_rates.pop_front();
			if (got.cell_index !== want.cell_index)
				report_mismatch($sformatf("cell_index got %0d exp %0d",
					got.cell_index, want.cell_index));
			if (got.rate !== want.rate)
				report_mismatch($sformatf("cell %0d: rate got %0d exp %0d",
					want.cell_index, got.rate, want.rate));
			if (got.max_speed !== want.max_speed)
				report_mismatch($sformatf("cell %0d: max_speed got %0d exp %0d",
					want.cell_index, got.max_speed, want.max_speed));
			if (got.status !== want.status)
				report_mismatch($sformatf("cell %0d: status got %0b exp %0b",
					want.cell_index, got.status, want.status));
			if (got.final_result !== want.final_result)
				report_mismatch($sformatf("cell %0d: final_result got %0b exp %0b",
					want.cell_index, got.final_result, want.final_result));
		endtask

		task check_leftover();
			if (pending_rates.size() != 0)
				report_mismatch($sformatf("%0d result items never arrived",
					pending_rates.size()));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	logic              pready;

	bgf_in_if  in_if();
	bgf_out_if out_if();

	godunov_rate_board board = new();
	bit steady;          // no gaps or stalls while set
	int items_sent;
	int rate_writes;
	int idle_cycles;

	burgers_godunov_flux_stencil_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_if),
		.results (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly no gap, some short ones, a few long
	function int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0, 1: return SAMPLE_W'($urandom);
			2: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
			3: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0001;
					3: return 16'shffff;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function logic [31:0] pick_width();
		logic [7:0] junk;
		junk = 8'($urandom);  // bits above the register are dropped
		case ($urandom_range(0, 5))
			0: return {junk, 24'h000000};
			1: return {junk, 24'hffffff};
			2: return {junk, INV_RESET};
			3: return {junk, 24'($urandom_range(1, 1024))};
			default: return {junk, 24'($urandom)};
		endcase
	endfunction

	// result side: random backpressure
	initial begin
		int stall;
		stall = 0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_if.ready <= 1'b0;
				stall--;
			end else begin
				out_if.ready <= 1'b1;
				stall = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_if.valid && in_if.ready)
			board.take_sample(in_if.sample, in_if.last_cell);
	end

	always @(posedge clk) begin
		rate_item_t got;
		if (arst_n && out_if.valid && out_if.ready) begin
			got.cell_index = out_if.cell_index;
			got.rate = out_if.rate;
			got.max_speed = out_if.max_speed;
			got.status = out_if.status;
			got.final_result = out_if.final_result;
			board.compare_rate(got);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
				(psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t watchdog: no handshake for %0d cycles, %0d items outstanding",
			$realtime, STALL_LIMIT, board.pending());
		$display("tb_top: FAIL");
		$finish;
	end

	task apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task check_readback();
		logic [31:0] rd;
		apb_read(INV_WIDTH_ADDR, rd);
		if (rd !== {8'h00, board.inv_width})
			board.report_mismatch($sformatf("inv_cell_width read %0h exp %0h",
				rd, board.inv_width));
	endtask

	task send_sample(input logic signed [SAMPLE_W-1:0] u, input logic last);
		int gap;
		gap = idle_len();
		repeat (gap) begin
			@(negedge clk);
			in_if.valid <= 1'b0;
		end
		@(negedge clk);
		in_if.valid <= 1'b1;
		in_if.sample <= u;
		in_if.last_cell <= last;
		do @(posedge clk); while (!in_if.ready);
		items_sent++;
	endtask

	task hold_sender();
		@(negedge clk);
		in_if.valid <= 1'b0;
	endtask

	// sender waits until every queued result item has come out
	task drain_pause();
		hold_sender();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task configure(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		drain_pause();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(addr, value);
		if (addr == INV_WIDTH_ADDR) begin
			board.inv_width = value[INV_W-1:0];
			rate_writes++;
		end
		check_readback();
	endtask

	task run_field(input int len);
		int k;
		for (k = 0; k < len; k++) begin
			if (k > 0 && k < len - 1 && $urandom_range(0, 39) == 0)
				drain_pause();
			send_sample(rand_sample(), k == len - 1);
		end
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.sample = '0;
		in_if.last_cell = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		items_sent = 0;
		rate_writes = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		check_readback();

		// extremes, all sign patterns at the faces, min sample for peak
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		drain_pause();
		send_sample(16'shffff, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);

		// short fields: one sample, then two
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh0005, 1'b0);
		send_sample(-16'sd7, 1'b1);

		// largest 1/dx saturates both ways
		configure(INV_WIDTH_ADDR, 32'hff_ffffff);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b1);

		configure(INV_WIDTH_ADDR, 32'h0000_0000);
		send_sample(16'sd1000, 1'b0);
		send_sample(-16'sd5, 1'b0);
		send_sample(16'sd7, 1'b1);

		// write to an unmapped slot must leave the register alone
		configure(SPARE_ADDR, 32'hdead_beef);
		configure(INV_WIDTH_ADDR, {8'h00, INV_RESET});

		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0)
				configure(INV_WIDTH_ADDR, pick_width());
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, 2);
				1: len = $urandom_range(20, 40);
				default: len = $urandom_range(3, 12);
			endcase
			run_field(len);
		end
		steady = 1'b0;

		drain_pause();
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.check_leftover();

		$display("tb_top: %0d samples in %0d fields (%0d short), %0d result items checked",
			items_sent, board.fields, board.short_fields, board.checked);
		$display("tb_top: %0d 1/dx settings incl. 0 and full scale, %0d mismatches",
			rate_writes, board.mismatches);
		if (board.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
